@@ hdl/complex_arith_unit_core_defines.svh @@
// Assertion macros shared by the complex ALU checker.
// No dependencies.
`ifndef COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed delay
`define CAU_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

@@ hdl/cau_pkg.sv @@
// Types, codes and helpers for the complex ALU.
// No dependencies; used by every RTL file of the block.
`default_nettype none
package cau_pkg;

    localparam int PROD_W  = 64;
    localparam int QBITS   = 34;
    localparam int DIV_W   = PROD_W + QBITS;
    localparam int LATENCY = 3 + QBITS + 1;

    typedef enum logic [3:0] {
        CMD_ADD       = 4'd0,
        CMD_SUB       = 4'd1,
        CMD_MUL       = 4'd2,
        CMD_SCALE_MUL = 4'd3,
        CMD_DIV       = 4'd4,
        CMD_SCALE_DIV = 4'd5,
        CMD_CONJ      = 4'd6,
        CMD_MOD2      = 4'd7,
        CMD_EQ        = 4'd8,
        CMD_NE        = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } smag_t;

    typedef struct packed {
        logic              valid;
        logic              div_op;
        logic              dz;
        logic              zero_out;
        logic              cmp;
        logic              huge_re;
        logic              huge_im;
        smag_t             re;
        smag_t             im;
        logic [PROD_W-1:0] den;
        logic [QBITS-1:0]  q_re;
        logic [QBITS-1:0]  q_im;
        logic [DIV_W-1:0]  r_re;
        logic [DIV_W-1:0]  r_im;
    } lane_t;

    function automatic smag_t to_smag(input logic signed [PROD_W:0] v);
        smag_t         r;
        logic [PROD_W:0] n;
        n     = -v;
        r.neg = v[PROD_W];
        r.mag = v[PROD_W] ? n[PROD_W-1:0] : v[PROD_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/cau_front.sv @@
// Front end: operand sign extension, products, compare and division setup.
// Three register stages; depends on cau_pkg.
`default_nettype none
module cau_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [3:0]    command,
    input  wire logic [31:0]   a_re,
    input  wire logic [31:0]   a_im,
    input  wire logic [31:0]   b_re,
    input  wire logic [31:0]   b_im,
    input  wire logic [4:0]    frac_keep,
    output cau_pkg::lane_t     lane_out
);
    import cau_pkg::*;

    localparam int RW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;

    function automatic logic [32:0] cmp_round(input logic signed [31:0] v,
                                              input logic [4:0] s);
        logic [31:0] mag;
        logic [32:0] t;
        logic [32:0] r;
        mag = v[31] ? 32'(-v) : 32'(v);
        t   = {mag, 1'b0} >> s;
        r   = 33'(mag >> s) + 33'(t[0]);
        return {v[31] && (r != '0), r[31:0]};
    endfunction

    function automatic smag_t rsh(input smag_t x);
        smag_t r;
        r     = x;
        r.mag = (x.mag >> FRAC_BITS) + PROD_W'(x.mag[FRAC_BITS-1]);
        return r;
    endfunction

    // stage 1
    logic signed [31:0] ar, ai, br, bi;
    logic signed [31:0] m0b, m1b;
    logic [4:0]         sh;
    cmd_t               cmd_in;

    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [32:0] sum_re_reg, sum_im_reg;
    logic signed [31:0] ar_reg, ai_reg, br_reg;
    logic               eq_reg;

    logic signed [63:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    logic signed [32:0] sum_re_next, sum_im_next;
    logic               eq_next;

    always_comb
    begin
        cmd_in = cmd_t'(command);
        ar  = $signed(a_re << (32 - RW)) >>> (32 - RW);
        ai  = $signed(a_im << (32 - RW)) >>> (32 - RW);
        br  = $signed(b_re << (32 - RW)) >>> (32 - RW);
        bi  = $signed(b_im << (32 - RW)) >>> (32 - RW);
        m0b = (cmd_in == CMD_MOD2) ? ar : br;
        m1b = (cmd_in == CMD_MOD2) ? ai : bi;
        p0_next = ar * m0b;
        p1_next = ai * m1b;
        p2_next = ar * bi;
        p3_next = ai * br;
        p4_next = br * br;
        p5_next = bi * bi;
        if (cmd_in == CMD_SUB)
        begin
            sum_re_next = ar - br;
            sum_im_next = ai - bi;
        end
        else
        begin
            sum_re_next = ar + br;
            sum_im_next = ai + bi;
        end
        sh = (32'(frac_keep) < FRAC_BITS) ? 5'(FRAC_BITS) - frac_keep : '0;
        eq_next = (cmp_round(ar, sh) == cmp_round(br, sh)) &&
                  (cmp_round(ai, sh) == cmp_round(bi, sh));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= cmd_in;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        p3_reg     <= p3_next;
        p4_reg     <= p4_next;
        p5_reg     <= p5_next;
        sum_re_reg <= sum_re_next;
        sum_im_reg <= sum_im_next;
        ar_reg     <= ar;
        ai_reg     <= ai;
        br_reg     <= br;
        eq_reg     <= eq_next;
    end

    // stage 2: operands of the final rounding or of the divider
    lane_t s2_next, s2_reg;
    smag_t sa, si, sb;

    always_comb
    begin
        sa = to_smag((PROD_W+1)'(ar_reg));
        si = to_smag((PROD_W+1)'(ai_reg));
        sb = to_smag((PROD_W+1)'(br_reg));
        s2_next       = '0;
        s2_next.valid = s1_valid_reg;
        case (s1_cmd_reg)
            CMD_ADD, CMD_SUB:
            begin
                s2_next.re = to_smag((PROD_W+1)'(sum_re_reg));
                s2_next.im = to_smag((PROD_W+1)'(sum_im_reg));
            end
            CMD_MUL:
            begin
                s2_next.re = rsh(to_smag((PROD_W+1)'(p0_reg) - (PROD_W+1)'(p1_reg)));
                s2_next.im = rsh(to_smag((PROD_W+1)'(p2_reg) + (PROD_W+1)'(p3_reg)));
            end
            CMD_SCALE_MUL:
            begin
                s2_next.re = rsh(to_smag((PROD_W+1)'(p0_reg)));
                s2_next.im = rsh(to_smag((PROD_W+1)'(p3_reg)));
            end
            CMD_DIV:
            begin
                s2_next.div_op = 1'b1;
                s2_next.re  = to_smag((PROD_W+1)'(p0_reg) + (PROD_W+1)'(p1_reg));
                s2_next.im  = to_smag((PROD_W+1)'(p3_reg) - (PROD_W+1)'(p2_reg));
                s2_next.den = $unsigned(p4_reg) + $unsigned(p5_reg);
                s2_next.dz  = (p4_reg == '0) && (p5_reg == '0);
            end
            CMD_SCALE_DIV:
            begin
                s2_next.div_op = 1'b1;
                s2_next.re.neg = sa.neg ^ sb.neg;
                s2_next.re.mag = sa.mag;
                s2_next.im.neg = si.neg ^ sb.neg;
                s2_next.im.mag = si.mag;
                s2_next.den    = sb.mag;
                s2_next.dz     = (br_reg == '0);
            end
            CMD_CONJ:
            begin
                s2_next.re = sa;
                s2_next.im = to_smag(-(PROD_W+1)'(ai_reg));
            end
            CMD_MOD2:
            begin
                s2_next.re = rsh(to_smag((PROD_W+1)'(p0_reg) + (PROD_W+1)'(p1_reg)));
            end
            CMD_EQ:
            begin
                s2_next.zero_out = 1'b1;
                s2_next.cmp      = eq_reg;
            end
            CMD_NE:
            begin
                s2_next.zero_out = 1'b1;
                s2_next.cmp      = !eq_reg;
            end
            default:
            begin
                s2_next.zero_out = 1'b1;
            end
        endcase
    end

    // stage 3: scaled dividends and the quotient range check
    lane_t            s3_next, s3_reg;
    logic [DIV_W-1:0] den_top;

    always_comb
    begin
        s3_next      = s2_reg;
        s3_next.r_re = DIV_W'(s2_reg.re.mag) << (FRAC_BITS + 1);
        s3_next.r_im = DIV_W'(s2_reg.im.mag) << (FRAC_BITS + 1);
        den_top      = {s2_reg.den, {QBITS{1'b0}}};
        s3_next.huge_re = (s3_next.r_re >= den_top);
        s3_next.huge_im = (s3_next.r_im >= den_top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
        end
        else
        begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign lane_out = s3_reg;

endmodule
`default_nettype wire

@@ hdl/cau_div_cell.sv @@
// One restoring-division cell: resolves quotient bit SHIFT of both parts.
// Depends on cau_pkg.
`default_nettype none
module cau_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  cau_pkg::lane_t lane_in,
    output cau_pkg::lane_t lane_out
);
    import cau_pkg::*;

    logic [DIV_W-1:0] dsh;
    logic             ge_re, ge_im;
    lane_t            lane_next, lane_reg;

    always_comb
    begin
        dsh       = DIV_W'(lane_in.den) << SHIFT;
        ge_re     = (lane_in.r_re >= dsh);
        ge_im     = (lane_in.r_im >= dsh);
        lane_next = lane_in;
        lane_next.q_re[SHIFT] = ge_re;
        lane_next.q_im[SHIFT] = ge_im;
        if (ge_re)
        begin
            lane_next.r_re = lane_in.r_re - dsh;
        end
        if (ge_im)
        begin
            lane_next.r_im = lane_in.r_im - dsh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg.valid <= 1'b0;
        end
        else
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
`default_nettype wire

@@ hdl/complex_arith_unit_core.sv @@
// Complex-number ALU top level: front end, division cell chain, output packing.
// Depends on cau_pkg, cau_front, cau_div_cell.
//
// channel  | handshake             | payload
// input    | start, busy           | command, a_re, a_im, b_re, b_im
// result   | done (1-cycle strobe) | res_re, res_im, compare_true, status
// config   | cfg_valid, cfg_ready  | cfg_data (compare_frac_bits)
//
// One item per cycle; every command passes from start to done through
// 3 front stages, 34 division cells (one quotient bit each) and 1 output stage.
// busy stays low and cfg_ready stays high; results cannot be held off.
// Reset clears the valid bits of every stage; compare_frac_bits resets to 10.
`default_nettype none
module complex_arith_unit_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  command,
    input  wire logic [31:0] a_re,
    input  wire logic [31:0] a_im,
    input  wire logic [31:0] b_re,
    input  wire logic [31:0] b_im,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    output logic             done,
    output logic [31:0]      res_re,
    output logic [31:0]      res_im,
    output logic             compare_true,
    output logic [1:0]       status
);
    import cau_pkg::*;

    localparam int RW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam logic [PROD_W-1:0] MAX_MAG = (PROD_W'(1) << (RW - 1)) - PROD_W'(1);

    logic [4:0] frac_keep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_keep_reg <= 5'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frac_keep_reg <= cfg_data;
        end
    end

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    lane_t chain [QBITS+1];

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .command   (command),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .frac_keep (frac_keep_reg),
        .lane_out  (chain[0])
    );

    for (genvar i = 0; i < QBITS; i++)
    begin : g_cell
        cau_div_cell #(
            .SHIFT (QBITS - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_in  (chain[i]),
            .lane_out (chain[i+1])
        );
    end

    function automatic logic [PROD_W:0] pack(input smag_t x);
        logic              sat;
        logic [PROD_W-1:0] m;
        sat = x.neg ? (x.mag > MAX_MAG + PROD_W'(1)) : (x.mag > MAX_MAG);
        m   = sat ? (x.neg ? MAX_MAG + PROD_W'(1) : MAX_MAG) : x.mag;
        return {sat, (x.neg ? -m : m)};
    endfunction

    lane_t             fin;
    logic [QBITS-1:0]  qr_re, qr_im;
    smag_t             v_re, v_im;
    logic [PROD_W:0]   pk_re, pk_im;
    logic [31:0]       res_re_next, res_im_next;
    logic              cmp_next;
    status_t           status_next;

    always_comb
    begin
        fin   = chain[QBITS];
        qr_re = (fin.q_re >> 1) + QBITS'(fin.q_re[0]);
        qr_im = (fin.q_im >> 1) + QBITS'(fin.q_im[0]);
        v_re  = fin.re;
        v_im  = fin.im;
        if (fin.div_op)
        begin
            v_re.mag = fin.huge_re ? '1 : PROD_W'(qr_re);
            v_im.mag = fin.huge_im ? '1 : PROD_W'(qr_im);
        end
        pk_re = pack(v_re);
        pk_im = pack(v_im);
        res_re_next = pk_re[31:0];
        res_im_next = pk_im[31:0];
        cmp_next    = 1'b0;
        status_next = (pk_re[PROD_W] || pk_im[PROD_W]) ? ST_SAT : ST_OK;
        if (fin.zero_out)
        begin
            res_re_next = '0;
            res_im_next = '0;
            cmp_next    = fin.cmp;
            status_next = ST_OK;
        end
        else if (fin.div_op && fin.dz)
        begin
            res_re_next = '0;
            res_im_next = '0;
            status_next = ST_DIV_ZERO;
        end
    end

    logic        done_reg;
    logic [31:0] res_re_reg, res_im_reg;
    logic        cmp_reg;
    status_t     status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        cmp_reg    <= cmp_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign res_re       = res_re_reg;
    assign res_im       = res_im_reg;
    assign compare_true = cmp_reg;
    assign status       = status_reg;

endmodule
`default_nettype wire

@@ hdl/cau_checker.sv @@
// Port-level checks for the complex ALU, bound to the top level.
// Depends on cau_pkg and complex_arith_unit_core_defines.svh.
`default_nettype none
`include "complex_arith_unit_core_defines.svh"
module cau_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] res_re,
    input wire logic [31:0] res_im,
    input wire logic        compare_true,
    input wire logic [1:0]  status
);
    import cau_pkg::*;

    `CAU_ASSERT_DLY(a_done_after_start, clk, rst_n, start && !busy, LATENCY, done, "item lost")
    `CAU_ASSERT_DLY(a_no_spurious, clk, rst_n, !(start && !busy), LATENCY, !done, "extra item")
    `CAU_ASSERT_IMP(a_dz_zero, clk, rst_n, done && (status == ST_DIV_ZERO), (res_re == '0) && (res_im == '0), "div by zero result not zero")
    `CAU_ASSERT_IMP(a_cmp_clean, clk, rst_n, done && compare_true, (status == ST_OK) && (res_re == '0) && (res_im == '0), "compare item with payload")

endmodule

bind complex_arith_unit_core cau_checker u_cau_checker (.*);
`default_nettype wire

@@ bench/tb_complex_arith_unit_core.sv @@
// Self-checking bench for complex_arith_unit_core: a queue-fed command driver, a result monitor
// and a bit-exact Q16.16 predictor for each command; compare precision is swept between phases.
// Depends on cau_pkg and the complex_arith_unit_core RTL.
`default_nettype none
module tb_complex_arith_unit_core;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC    = 16;
    localparam int SETTLE  = 50;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    typedef enum logic [1:0] {K_ITEM, K_SYNC, K_CFG} kind_t;

    typedef struct {
        kind_t              kind;
        logic [3:0]         cmd;
        logic signed [31:0] a_re, a_im, b_re, b_im;
        int                 gap;
        logic [4:0]         cfg;
    } op_t;

    typedef struct {
        logic [31:0] re, im;
        logic        cmp;
        logic [1:0]  st;
    } alu_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [3:0]  command = '0;
    logic [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic        cfg_valid = 1'b0;
    logic [4:0]  cfg_data = '0;
    wire         busy, cfg_ready, done, compare_true;
    wire [31:0]  res_re, res_im;
    wire [1:0]   status;

    op_t      pending_ops[$];
    alu_res_t expected_res[$];
    logic [4:0] cmp_frac_bits = 5'd10;
    int       err_count = 0;
    int       wait_left = 0;

    complex_arith_unit_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .res_re(res_re), .res_im(res_im),
        .compare_true(compare_true), .status(status)
    );

    always #4 clk = ~clk;

    // {saturated, clamped value}
    function automatic logic [32:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sh7fff_ffff)
            return {1'b1, MAXV};
        if (v < -128'sh8000_0000)
            return {1'b1, MINV};
        return {1'b0, v[31:0]};
    endfunction

    // round to nearest, ties away from zero
    function automatic logic signed [127:0] round_shift(input logic signed [127:0] v, input int s);
        logic [127:0] mag;
        if (s == 0)
            return v;
        mag = (v < 0) ? -v : v;
        mag = (mag >> s) + ((mag >> (s - 1)) & 128'd1);
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [127:0] fix_div(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
        logic [127:0] nm, dm, q, r;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        nm = nm << FRAC;
        q = nm / dm;
        r = nm % dm;
        if (2 * r >= dm)
            q = q + 1;
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic alu_res_t predict(input op_t it);
        logic signed [127:0] ar, ai, br, bi, m;
        logic [32:0] t_re, t_im;
        alu_res_t r;
        int s;
        logic eq;
        ar = it.a_re; ai = it.a_im; br = it.b_re; bi = it.b_im;
        r.re = '0; r.im = '0; r.cmp = 1'b0; r.st = ST_OK;
        t_re = '0; t_im = '0;
        case (it.cmd)
            CMD_ADD: begin t_re = clamp32(ar + br); t_im = clamp32(ai + bi); end
            CMD_SUB: begin t_re = clamp32(ar - br); t_im = clamp32(ai - bi); end
            CMD_MUL:
            begin
                t_re = clamp32(round_shift(ar * br - ai * bi, FRAC));
                t_im = clamp32(round_shift(ar * bi + ai * br, FRAC));
            end
            CMD_SCALE_MUL:
            begin
                t_re = clamp32(round_shift(ar * br, FRAC));
                t_im = clamp32(round_shift(ai * br, FRAC));
            end
            CMD_DIV:
            begin
                m = br * br + bi * bi;
                if (m == 0)
                    r.st = ST_DIV_ZERO;
                else
                begin
                    t_re = clamp32(fix_div(ar * br + ai * bi, m));
                    t_im = clamp32(fix_div(ai * br - ar * bi, m));
                end
            end
            CMD_SCALE_DIV:
            begin
                if (br == 0)
                    r.st = ST_DIV_ZERO;
                else
                begin
                    t_re = clamp32(fix_div(ar, br));
                    t_im = clamp32(fix_div(ai, br));
                end
            end
            CMD_CONJ: begin t_re = {1'b0, it.a_re}; t_im = clamp32(-ai); end
            CMD_MOD2: t_re = clamp32(round_shift(ar * ar + ai * ai, FRAC));
            CMD_EQ, CMD_NE:
            begin
                s = (cmp_frac_bits < FRAC) ? FRAC - cmp_frac_bits : 0;
                eq = (round_shift(ar, s) == round_shift(br, s)) &&
                     (round_shift(ai, s) == round_shift(bi, s));
                r.cmp = (it.cmd == CMD_EQ) ? eq : !eq;
            end
            default: ;
        endcase
        r.re = t_re[31:0];
        r.im = t_im[31:0];
        if (t_re[32] || t_im[32])
            r.st = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        logic nstart, ncfg;
        op_t it;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
            wait_left = 0;
        end
        else
        begin
            nstart = start;
            ncfg = cfg_valid;
            if (start && !busy)
            begin
                it.kind = K_ITEM; it.cmd = command; it.a_re = a_re; it.a_im = a_im;
                it.b_re = b_re; it.b_im = b_im; it.gap = 0; it.cfg = '0;
                expected_res.push_back(predict(it));
                nstart = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                cmp_frac_bits = cfg_data;
                ncfg = 1'b0;
            end
            if (!nstart && !ncfg)
            begin
                if (wait_left > 0)
                    wait_left--;
                else if (pending_ops.size() > 0)
                begin
                    it = pending_ops[0];
                    case (it.kind)
                        K_ITEM:
                        begin
                            if (it.gap > 0)
                                pending_ops[0].gap--;
                            else
                            begin
                                void'(pending_ops.pop_front());
                                command <= it.cmd;
                                a_re <= it.a_re; a_im <= it.a_im;
                                b_re <= it.b_re; b_im <= it.b_im;
                                nstart = 1'b1;
                            end
                        end
                        K_SYNC:
                        begin
                            if (expected_res.size() == 0)
                            begin
                                void'(pending_ops.pop_front());
                                wait_left = SETTLE;
                            end
                        end
                        default:
                        begin
                            void'(pending_ops.pop_front());
                            cfg_data <= it.cfg;
                            ncfg = 1'b1;
                        end
                    endcase
                end
            end
            start <= nstart;
            cfg_valid <= ncfg;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        alu_res_t w;
        if (rst_n && done)
        begin
            if (expected_res.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                err_count++;
            end
            else
            begin
                w = expected_res.pop_front();
                if (res_re !== w.re) report_mismatch("res_re", res_re, w.re);
                if (res_im !== w.im) report_mismatch("res_im", res_im, w.im);
                if (compare_true !== w.cmp)
                    report_mismatch("compare_true", {31'd0, compare_true}, {31'd0, w.cmp});
                if (status !== w.st) report_mismatch("status", {30'd0, status}, {30'd0, w.st});
            end
        end
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ($urandom_range(0, 1) != 0) ? MAXV : MINV;
            2: return $urandom_range(0, 3) << 16;
            3: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            4: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input logic [3:0] cmd, input logic [31:0] ar, input logic [31:0] ai,
                          input logic [31:0] br, input logic [31:0] bi, input int gap);
        op_t it;
        it.kind = K_ITEM; it.cmd = cmd; it.a_re = ar; it.a_im = ai;
        it.b_re = br; it.b_im = bi; it.gap = gap; it.cfg = '0;
        pending_ops.push_back(it);
    endtask

    task automatic add_ctl(input kind_t k, input logic [4:0] v);
        op_t it;
        it.kind = k; it.cmd = '0; it.a_re = '0; it.a_im = '0;
        it.b_re = '0; it.b_im = '0; it.gap = 0; it.cfg = v;
        pending_ops.push_back(it);
    endtask

    task automatic add_random(input int n, input bit bursty);
        logic [3:0] cmd;
        logic [31:0] ar, ai, br, bi;
        int gap;
        for (int i = 0; i < n; i++)
        begin
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
            ar = rand_val(); ai = rand_val(); br = rand_val(); bi = rand_val();
            if ((cmd == CMD_EQ || cmd == CMD_NE) && $urandom_range(0, 2) != 0)
            begin
                // near-equal operands exercise the rounding boundary
                br = ar + $signed($urandom_range(0, 1 << 8)) - (1 << 7);
                bi = ai + $signed($urandom_range(0, 1 << 8)) - (1 << 7);
            end
            gap = bursty ? 0 : $urandom_range(0, 16);
            add_op(cmd, ar, ai, br, bi, gap);
        end
    endtask

    initial
    begin
        logic [4:0] cfg_list[6];
        cfg_list = '{5'd0, 5'd16, 5'd15, 5'd7, 5'($urandom_range(0, 16)), 5'd10};

        add_op(CMD_ADD, MAXV, MAXV, MAXV, 32'd1, 0);
        add_op(CMD_ADD, MINV, MINV, MINV, 32'hffff_ffff, 0);
        add_op(CMD_SUB, MINV, MAXV, MAXV, MINV, 0);
        add_op(CMD_MUL, MAXV, MINV, MAXV, MINV, 0);
        add_op(CMD_MUL, 32'h0001_8000, 32'h0000_8000, 32'h0002_0000, 32'hffff_0000, 3);
        add_op(CMD_SCALE_MUL, MINV, MAXV, MINV, 32'h1234_5678, 0);
        add_op(CMD_SCALE_MUL, 32'h0000_0001, 32'hffff_ffff, 32'h0000_8000, 32'd0, 0);
        add_op(CMD_DIV, 32'h0001_0000, 32'h0002_0000, 32'd0, 32'd0, 0);
        add_op(CMD_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 2);
        add_op(CMD_DIV, MINV, MAXV, 32'd1, 32'd1, 0);
        add_op(CMD_SCALE_DIV, 32'h0001_0000, MAXV, 32'd0, 32'h0000_5555, 0);
        add_op(CMD_SCALE_DIV, MINV, MAXV, 32'hffff_0000, 32'd7, 0);
        add_op(CMD_SCALE_DIV, 32'h0001_0000, 32'hfffe_0000, 32'h0003_0000, 32'd0, 0);
        add_op(CMD_CONJ, MAXV, MINV, 32'd0, 32'd0, 0);
        add_op(CMD_CONJ, MINV, MAXV, 32'd5, 32'd5, 1);
        add_op(CMD_MOD2, MAXV, MINV, 32'd0, 32'd0, 0);
        add_op(CMD_MOD2, 32'h0000_0100, 32'hffff_ff00, 32'd0, 32'd0, 0);
        add_op(CMD_EQ, 32'h0001_0020, MINV, 32'h0001_0000, MINV, 0);
        add_op(CMD_EQ, 32'h0001_0000, 32'd0, 32'h0001_0000, 32'd1, 0);
        add_op(CMD_NE, 32'h0000_0020, 32'hffff_ffe0, 32'h0000_0040, 32'hffff_ffc0, 0);
        add_op(CMD_NE, MAXV, MAXV, MAXV, MAXV, 0);
        add_op(4'd10, MAXV, MAXV, MAXV, MAXV, 0);
        add_op(4'd15, MINV, MINV, MINV, MINV, 0);
        add_random(40, 0);

        foreach (cfg_list[p])
        begin
            add_ctl(K_SYNC, '0);
            add_ctl(K_CFG, cfg_list[p]);
            add_random(120, 1);
            add_random(140, 0);
            add_ctl(K_SYNC, '0);
            add_random(60, p % 2 == 0);
        end

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        wait (pending_ops.size() == 0 && !start && !cfg_valid && expected_res.size() == 0);
        repeat (60) @(posedge clk);
        if (err_count == 0 && expected_res.size() == 0)
            $display("complex_arith_unit_core test passed");
        else
            $display("complex_arith_unit_core test failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("complex_arith_unit_core test failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_div_cell.sv
hdl/complex_arith_unit_core.sv
hdl/cau_checker.sv
bench/tb_complex_arith_unit_core.sv
